FILE: sv/rlp_header_decoder_core_macros.svh
// ----------------------------------------------------------------------------
// rlp_header_decoder_core_macros
// Assertion helpers for the RLP header decoder.
// ----------------------------------------------------------------------------
`ifndef RLP_HEADER_DECODER_CORE_MACROS_SVH
`define RLP_HEADER_DECODER_CORE_MACROS_SVH

// same-cycle implication
`define RLPHD_ASSERT_NOW(label, clock, reset, cond, prop) \
  label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
    else $error("rlphd: same-cycle check failed");

// next-cycle implication
`define RLPHD_ASSERT_NEXT(label, clock, reset, cond, prop) \
  label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
    else $error("rlphd: next-cycle check failed");

`endif

FILE: sv/rlphd_pkg.sv
// ----------------------------------------------------------------------------
// rlphd_pkg
// Types and constants shared by the RLP header decoder.
// ----------------------------------------------------------------------------
package rlphd_pkg;

  localparam int LEN_WIDTH = 32;
  localparam int SUM_W     = ((LEN_WIDTH > 32) ? LEN_WIDTH : 32) + 1;

  localparam logic [7:0] SINGLE_MAX     = 8'h7f;
  localparam logic [7:0] STR_BASE       = 8'h80;
  localparam logic [7:0] SHORT_STR_MAX  = 8'hb7;
  localparam logic [7:0] LONG_STR_MAX   = 8'hbf;
  localparam logic [7:0] LIST_BASE      = 8'hc0;
  localparam logic [7:0] SHORT_LIST_MAX = 8'hf7;
  localparam logic [3:0] MAX_STR_LOL    = 4'd4;
  localparam logic [3:0] MAX_LIST_LOL   = 4'd3;

  typedef enum logic [1:0] {
    KIND_SINGLE = 2'd0,
    KIND_STRING = 2'd1,
    KIND_LIST   = 2'd2
  } kind_t;

  typedef struct packed {
    logic        header_start;
    logic [7:0]  data_byte;
    logic [31:0] bytes_available;
  } item_t;

  typedef struct packed {
    logic [1:0]  item_kind;
    logic [31:0] payload_length;
    logic [2:0]  payload_offset;
    logic [31:0] total_consumed;
    logic        header_error;
  } result_t;

endpackage

FILE: sv/rlphd_in_if.sv
// ----------------------------------------------------------------------------
// rlphd_in_if
// Header byte channel: one header byte per transaction.
// ----------------------------------------------------------------------------
interface rlphd_in_if;
  logic        valid;
  logic        ready;
  logic        header_start;
  logic [7:0]  data_byte;
  logic [31:0] bytes_available;

  modport source (output valid, header_start, data_byte, bytes_available, input ready);
  modport sink   (input valid, header_start, data_byte, bytes_available, output ready);
endinterface

FILE: sv/rlphd_out_if.sv
// ----------------------------------------------------------------------------
// rlphd_out_if
// Decoded header channel: one header result per transaction.
// ----------------------------------------------------------------------------
interface rlphd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  item_kind;
  logic [31:0] payload_length;
  logic [2:0]  payload_offset;
  logic [31:0] total_consumed;
  logic        header_error;

  modport source (output valid, item_kind, payload_length, payload_offset,
                  total_consumed, header_error, input ready);
  modport sink   (input valid, item_kind, payload_length, payload_offset,
                  total_consumed, header_error, output ready);
endinterface

FILE: sv/rlphd_in_stage.sv
// ----------------------------------------------------------------------------
// rlphd_in_stage
// Input register: holds one accepted header byte until the decoder takes it.
// ----------------------------------------------------------------------------
module rlphd_in_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  rlphd_pkg::item_t  in_item,
  input  logic              advance,
  output logic              stage_valid,
  output rlphd_pkg::item_t  stage_item
);

  logic take;

  assign in_ready = !stage_valid || advance;
  assign take     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else begin
      stage_valid <= take || (stage_valid && !advance);
    end
    if (take) begin
      stage_item <= in_item;
    end
  end

endmodule

FILE: sv/rlphd_decode.sv
// ----------------------------------------------------------------------------
// rlphd_decode
// Prefix classification, length-byte accumulation and buffer bound check.
// ----------------------------------------------------------------------------
module rlphd_decode (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  rlphd_pkg::item_t    item,
  output logic                emit,
  output rlphd_pkg::result_t  res
);

  typedef enum logic {
    WAIT_PREFIX,
    COLLECT
  } phase_t;

  phase_t                             phase, phase_next;
  logic [2:0]                         left, left_next;
  logic [rlphd_pkg::LEN_WIDTH-1:0]    acc, acc_next;
  rlphd_pkg::kind_t                   kind_held, kind_next;
  logic [2:0]                         header_size, size_next;
  logic [31:0]                        avail_held, avail_next;

  logic                               do_err, do_finish, long_form, over;
  rlphd_pkg::kind_t                   fin_kind;
  logic [rlphd_pkg::LEN_WIDTH-1:0]    fin_len, acc_shift;
  logic [2:0]                         fin_off;
  logic [31:0]                        fin_avail;
  logic [3:0]                         lol, limit;
  logic [rlphd_pkg::SUM_W-1:0]        sum, len_ext;

  always_comb begin
    phase_next = phase;
    left_next  = left;
    acc_next   = acc;
    kind_next  = kind_held;
    size_next  = header_size;
    avail_next = avail_held;
    do_err     = 1'b0;
    do_finish  = 1'b0;
    long_form  = 1'b0;
    fin_kind   = rlphd_pkg::KIND_SINGLE;
    fin_len    = '0;
    fin_off    = 3'd0;
    fin_avail  = item.bytes_available;
    lol        = 4'd0;
    limit      = 4'd0;
    acc_shift  = {acc[rlphd_pkg::LEN_WIDTH-9:0], item.data_byte};

    if (item.header_start) begin
      avail_next = item.bytes_available;
      if (item.bytes_available == 32'd0) begin
        do_err = 1'b1;
      end else if (item.data_byte <= rlphd_pkg::SINGLE_MAX) begin
        do_finish = 1'b1;
        fin_kind  = rlphd_pkg::KIND_SINGLE;
        fin_len   = rlphd_pkg::LEN_WIDTH'(1);
      end else if (item.data_byte <= rlphd_pkg::SHORT_STR_MAX) begin
        do_finish = 1'b1;
        fin_kind  = rlphd_pkg::KIND_STRING;
        fin_len   = rlphd_pkg::LEN_WIDTH'(item.data_byte - rlphd_pkg::STR_BASE);
        fin_off   = 3'd1;
      end else if (item.data_byte <= rlphd_pkg::LONG_STR_MAX) begin
        long_form = 1'b1;
        kind_next = rlphd_pkg::KIND_STRING;
        lol       = 4'(item.data_byte - rlphd_pkg::SHORT_STR_MAX);
        limit     = rlphd_pkg::MAX_STR_LOL;
      end else if (item.data_byte <= rlphd_pkg::SHORT_LIST_MAX) begin
        do_finish = 1'b1;
        fin_kind  = rlphd_pkg::KIND_LIST;
        fin_len   = rlphd_pkg::LEN_WIDTH'(item.data_byte - rlphd_pkg::LIST_BASE);
        fin_off   = 3'd1;
      end else begin
        long_form = 1'b1;
        kind_next = rlphd_pkg::KIND_LIST;
        lol       = 4'(item.data_byte - rlphd_pkg::SHORT_LIST_MAX);
        limit     = rlphd_pkg::MAX_LIST_LOL;
      end
      if (long_form) begin
        if ((33'(lol) + 33'd1 > 33'(item.bytes_available)) || (lol > limit)) begin
          do_err = 1'b1;
        end else begin
          left_next  = lol[2:0];
          size_next  = 3'(lol + 4'd1);
          acc_next   = '0;
          phase_next = COLLECT;
        end
      end
    end else if (phase == COLLECT) begin
      acc_next  = acc_shift;
      left_next = left - 3'd1;
      if (left == 3'd1) begin
        do_finish = 1'b1;
        fin_kind  = kind_held;
        fin_len   = acc_shift;
        fin_off   = header_size;
        fin_avail = avail_held;
      end
    end

    len_ext = rlphd_pkg::SUM_W'(fin_len);
    sum     = len_ext + rlphd_pkg::SUM_W'(fin_off);
    over    = sum > rlphd_pkg::SUM_W'(fin_avail);
    emit    = do_err || do_finish;

    if (emit) begin
      phase_next = WAIT_PREFIX;
      left_next  = 3'd0;
    end

    if (do_err || over) begin
      res = '0;
      res.header_error = 1'b1;
    end else begin
      res.item_kind      = fin_kind;
      res.payload_length = len_ext[31:0];
      res.payload_offset = fin_off;
      res.total_consumed = sum[31:0];
      res.header_error   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= WAIT_PREFIX;
      left        <= 3'd0;
      acc         <= '0;
      kind_held   <= rlphd_pkg::KIND_SINGLE;
      header_size <= 3'd0;
      avail_held  <= 32'd0;
    end else if (fire) begin
      phase       <= phase_next;
      left        <= left_next;
      acc         <= acc_next;
      kind_held   <= kind_next;
      header_size <= size_next;
      avail_held  <= avail_next;
    end
  end

endmodule

FILE: sv/rlphd_out_stage.sv
// ----------------------------------------------------------------------------
// rlphd_out_stage
// Result register: holds one decoded header until the sink takes it.
// ----------------------------------------------------------------------------
module rlphd_out_stage (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  rlphd_pkg::result_t  load_res,
  output logic                can_load,
  output logic                out_valid,
  input  logic                out_ready,
  output rlphd_pkg::result_t  out_res
);

  assign can_load = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= load || (out_valid && !out_ready);
    end
    if (load) begin
      out_res <= load_res;
    end
  end

endmodule

FILE: sv/rlp_header_decoder_core.sv
// ----------------------------------------------------------------------------
// rlp_header_decoder_core
// RLP header decoder: classifies the prefix, gathers long-form length bytes,
// checks the header against the buffer and reports one result per header.
//
//   channel  dir  transaction
//   header   in   one header byte (prefix with buffer size, or length byte)
//   result   out  kind, payload length/offset, total consumed, error flag
//
// One header byte per cycle sustained while no result is stalled; an accepted
// byte passes the input register, then is decoded into the result register.
// A header yields its result on the prefix or on its last length byte.
// Reset is synchronous and clears all decoder state and valid flags.
// A stalled result blocks only bytes that would produce another result;
// bytes that only advance the length accumulator keep flowing.
// ----------------------------------------------------------------------------
`include "rlp_header_decoder_core_macros.svh"

module rlp_header_decoder_core (
  input  logic        clk,
  input  logic        rst,
  rlphd_in_if.sink    header,
  rlphd_out_if.source result
);

  rlphd_pkg::item_t   in_item, stage_item;
  rlphd_pkg::result_t dec_res, out_res;
  logic               stage_valid, advance, emit, can_load, out_valid;
  logic               err_out, ok_out, single_out, zero_fields, sum_match, single_shape;

  assign in_item.header_start    = header.header_start;
  assign in_item.data_byte       = header.data_byte;
  assign in_item.bytes_available = header.bytes_available;

  assign advance = stage_valid && (can_load || !emit);

  rlphd_in_stage u_in (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (header.valid),
    .in_ready    (header.ready),
    .in_item     (in_item),
    .advance     (advance),
    .stage_valid (stage_valid),
    .stage_item  (stage_item)
  );

  rlphd_decode u_dec (
    .clk  (clk),
    .rst  (rst),
    .fire (advance),
    .item (stage_item),
    .emit (emit),
    .res  (dec_res)
  );

  rlphd_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (advance && emit),
    .load_res  (dec_res),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (result.ready),
    .out_res   (out_res)
  );

  assign result.valid          = out_valid;
  assign result.item_kind      = out_res.item_kind;
  assign result.payload_length = out_res.payload_length;
  assign result.payload_offset = out_res.payload_offset;
  assign result.total_consumed = out_res.total_consumed;
  assign result.header_error   = out_res.header_error;

  assign err_out      = result.valid && result.header_error;
  assign ok_out       = result.valid && !result.header_error;
  assign single_out   = ok_out && (result.item_kind == rlphd_pkg::KIND_SINGLE);
  assign zero_fields  = (result.item_kind == rlphd_pkg::KIND_SINGLE) &&
                        (result.payload_length == 32'd0) &&
                        (result.payload_offset == 3'd0) &&
                        (result.total_consumed == 32'd0);
  assign sum_match    = result.total_consumed ==
                        (result.payload_length + 32'(result.payload_offset));
  assign single_shape = (result.payload_offset == 3'd0) && (result.payload_length == 32'd1);

  `RLPHD_ASSERT_NOW(a_err_zero, clk, rst, err_out, zero_fields)
  `RLPHD_ASSERT_NOW(a_total_sum, clk, rst, ok_out, sum_match)
  `RLPHD_ASSERT_NOW(a_single_form, clk, rst, single_out, single_shape)

endmodule
